@@ sv/mtrd_pkg.sv @@
`default_nettype none

package mtrd_pkg;

  // Word and table geometry
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;

  // Seeding and twist constants
  localparam logic [WORD_W-1:0] SEED_RESET  = 32'd4357;
  localparam logic [WORD_W-1:0] SEED_MULT   = 32'd69069;
  localparam logic [WORD_W-1:0] MATRIX_WORD = 32'h9908b0df;

  // Tempering masks
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc60000;

  // A word with a one-cycle valid strobe
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] data;
  } mtrd_word_t;

  // Seed register write
  typedef struct packed {
    logic              write;
    logic [WORD_W-1:0] data;
  } mtrd_seed_t;

  // Standard output tempering
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in ^ (y_in >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

@@ sv/mtrd_ram.sv @@
`default_nettype none

module mtrd_ram #(
  parameter int unsigned WIDTH = mtrd_pkg::WORD_W,
  parameter int unsigned DEPTH = mtrd_pkg::STATE_WORDS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output      logic [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

@@ sv/mtrd_mod.sv @@
`default_nettype none

module mtrd_mod (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [mtrd_pkg::WORD_W-1:0]     dividend,
  input  wire logic [mtrd_pkg::WORD_W-1:0]     divisor,
  output      mtrd_pkg::mtrd_word_t            result
);

  localparam int unsigned W  = mtrd_pkg::WORD_W;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  quo_sr;
  logic [W-1:0]  rem;
  logic [W-1:0]  divisor_q;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic [W-1:0]  rem_next;

  // Shift in one dividend bit, subtract the divisor when it fits
  assign trial    = {rem, quo_sr[W-1]};
  assign diff     = trial - {1'b0, divisor_q};
  assign rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      result.valid <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= '0;
        quo_sr    <= dividend;
        rem       <= '0;
        divisor_q <= divisor;
      end else if (busy) begin
        rem    <= rem_next;
        quo_sr <= quo_sr << 1;
        count  <= count + 1'b1;
        // Last bit: publish the remainder
        if (count == LAST_BIT) begin
          busy         <= 1'b0;
          result.valid <= 1'b1;
          result.data  <= rem_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/mtrd_gen.sv @@
`default_nettype none

module mtrd_gen #(
  parameter int unsigned STATE_WORDS = mtrd_pkg::STATE_WORDS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire mtrd_pkg::mtrd_seed_t seed_wr,
  output      mtrd_pkg::mtrd_word_t word
);

  localparam int unsigned W        = mtrd_pkg::WORD_W;
  localparam int unsigned AW       = $clog2(STATE_WORDS);
  localparam int unsigned LOW_SPAN = STATE_WORDS - mtrd_pkg::TWIST_OFFSET;
  localparam logic [AW-1:0] LAST_IDX   = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] OFFSET_IDX = AW'(mtrd_pkg::TWIST_OFFSET);
  localparam logic [AW-1:0] SPAN_IDX   = AW'(LOW_SPAN);

  typedef enum logic [2:0] {
    G_IDLE,
    G_SEED,
    G_RD0,
    G_RD1,
    G_CALC
  } gen_state_t;

  gen_state_t    state;
  logic          pending;
  logic [W-1:0]  seed_val;
  logic [AW-1:0] fill_idx;
  logic [W-1:0]  fill_word;
  logic [AW-1:0] rd_idx;
  logic [W-1:0]  y_mix;

  logic [W-1:0]   fill_prod;
  logic [AW-1:0]  nxt_idx;
  logic [AW-1:0]  far_idx;
  logic [W-1:0]   twisted;

  logic          we;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [W-1:0]  rd_data_a;
  logic [W-1:0]  rd_data_b;

  // Seed recurrence: next word is the product truncated to the word
  assign fill_prod = fill_word * mtrd_pkg::SEED_MULT;

  // Neighbor and far index of the word being twisted
  assign nxt_idx = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
  assign far_idx = (rd_idx < SPAN_IDX) ? rd_idx + OFFSET_IDX : rd_idx - SPAN_IDX;

  // Twist one word in place; lower indexes already hold the new generation
  assign twisted = rd_data_a ^ (y_mix >> 1) ^ (y_mix[0] ? mtrd_pkg::MATRIX_WORD : '0);

  // Memory port steering
  assign we        = (state == G_SEED) || (state == G_CALC);
  assign wr_addr   = (state == G_SEED) ? fill_idx : rd_idx;
  assign wr_data   = (state == G_SEED) ? fill_word : twisted;
  assign rd_addr_a = (state == G_RD1) ? far_idx : rd_idx;

  mtrd_ram #(
    .WIDTH (W),
    .DEPTH (STATE_WORDS)
  ) u_ram (
    .clk       (clk),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (nxt_idx),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= G_IDLE;
      pending    <= 1'b1;
      seed_val   <= mtrd_pkg::SEED_RESET;
      rd_idx     <= '0;
      word.valid <= 1'b0;
    end else begin
      word.valid <= 1'b0;
      case (state)
        G_IDLE: begin
          if (start) begin
            if (pending) begin
              fill_word <= seed_val;
              fill_idx  <= '0;
              state     <= G_SEED;
            end else begin
              state <= G_RD0;
            end
          end
        end
        // Fill the table one word per cycle
        G_SEED: begin
          fill_word <= fill_prod;
          fill_idx  <= fill_idx + 1'b1;
          if (fill_idx == LAST_IDX) begin
            pending <= 1'b0;
            rd_idx  <= '0;
            state   <= G_RD0;
          end
        end
        G_RD0: begin
          state <= G_RD1;
        end
        // Merge top bit of this word with low bits of the next
        G_RD1: begin
          y_mix <= {rd_data_a[W-1], rd_data_b[W-2:0]};
          state <= G_CALC;
        end
        // Write back the twisted word and hand out its tempered form
        G_CALC: begin
          word.data  <= mtrd_pkg::temper(twisted);
          word.valid <= 1'b1;
          rd_idx     <= nxt_idx;
          state      <= G_IDLE;
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
      // A seed write forces a reseed on the next draw
      if (seed_wr.write) begin
        seed_val <= seed_wr.data;
        pending  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/mersenne_twister_ranged_draw_unit.sv @@
// An accepted item goes through the generator (three table reads and the write-back
// of the twisted word) and then the bit-serial remainder before rsp_valid; a zero
// range_limit skips both. The first draw after reset or after a seed write first fills
// the table. A new item is taken only once the last has reached the output register.
// Reset (rst, synchronous, active high) loads seed 4357 and marks a reseed pending;
// the table itself is not cleared.
`default_nettype none

module mersenne_twister_ranged_draw_unit #(
  parameter int unsigned STATE_WORDS = mtrd_pkg::STATE_WORDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output      logic                        req_stall,
  input  wire logic [mtrd_pkg::WORD_W-1:0] range_limit,
  output      logic                        rsp_valid,
  input  wire logic                        rsp_stall,
  output      logic [mtrd_pkg::WORD_W-1:0] value,
  input  wire logic                        seed_valid,
  output      logic                        seed_ready,
  input  wire logic [mtrd_pkg::WORD_W-1:0] seed
);

  localparam int unsigned W = mtrd_pkg::WORD_W;

  typedef enum logic [1:0] {
    T_IDLE,
    T_GEN,
    T_DIV,
    T_FIN
  } top_state_t;

  top_state_t state;
  logic       gen_start;
  logic       div_start;
  logic [W-1:0] limit_q;
  logic [W-1:0] result_q;

  logic                 req_take;
  mtrd_pkg::mtrd_seed_t seed_wr;
  mtrd_pkg::mtrd_word_t gen_word;
  mtrd_pkg::mtrd_word_t div_res;

  // Take a seed only while idle and no item is offered
  assign req_stall    = (state != T_IDLE);
  assign seed_ready   = (state == T_IDLE) && !req_valid;
  assign req_take     = req_valid && !req_stall;
  assign seed_wr.write = seed_valid && seed_ready;
  assign seed_wr.data  = seed;

  mtrd_gen #(
    .STATE_WORDS (STATE_WORDS)
  ) u_gen (
    .clk     (clk),
    .rst     (rst),
    .start   (gen_start),
    .seed_wr (seed_wr),
    .word    (gen_word)
  );

  mtrd_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (gen_word.data),
    .divisor  (limit_q),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      gen_start <= 1'b0;
      div_start <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      gen_start <= 1'b0;
      div_start <= 1'b0;
      // Drop the result once taken
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (req_take) begin
            limit_q <= range_limit;
            if (range_limit == '0) begin
              result_q <= '0;
              state    <= T_FIN;
            end else begin
              gen_start <= 1'b1;
              state     <= T_GEN;
            end
          end
        end
        T_GEN: begin
          if (gen_word.valid) begin
            div_start <= 1'b1;
            state     <= T_DIV;
          end
        end
        T_DIV: begin
          if (div_res.valid) begin
            result_q <= div_res.data;
            state    <= T_FIN;
          end
        end
        // Load the output register as soon as it is free
        T_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            value     <= result_q;
            state     <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/mtrd_checker.sv @@
`default_nettype none

module mtrd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_stall,
  input wire logic [mtrd_pkg::WORD_W-1:0] range_limit,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_stall,
  input wire logic [mtrd_pkg::WORD_W-1:0] value,
  input wire logic                        seed_valid,
  input wire logic                        seed_ready
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(value))
    else $error("stalled result changed");

  // Stall after taking an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item taken while still idle");

  // A zero limit answers zero when the output is free as the item is taken
  a_zero_limit: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (range_limit == '0) && (!rsp_valid || !rsp_stall)
    |-> ##2 rsp_valid && (value == '0))
    else $error("zero limit did not yield zero");

  // A new result only follows work on an item
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared without an item in progress");

  // Seed writes are taken only while idle
  a_seed_idle: assert property (@(posedge clk) disable iff (rst)
    seed_valid && seed_ready |-> !req_stall)
    else $error("seed write taken while busy");

endmodule

bind mersenne_twister_ranged_draw_unit mtrd_checker u_mtrd_checker (.*);

`default_nettype wire

@@ dv/mtrd_draw_checker.sv @@
`timescale 1ns / 1ps

module mtrd_draw_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic [mtrd_pkg::WORD_W-1:0] range_limit,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic [mtrd_pkg::WORD_W-1:0] value,
  input  logic                        seed_valid,
  input  logic                        seed_ready,
  input  logic [mtrd_pkg::WORD_W-1:0] seed,
  output int                          fail_count,
  output int                          outstanding
);

  // Shadow copy of the generator: table, read pointer and seed register
  logic [mtrd_pkg::WORD_W-1:0] mt_words [mtrd_pkg::STATE_WORDS];
  logic [9:0]                  word_idx;
  logic [mtrd_pkg::WORD_W-1:0] seed_reg;
  logic [mtrd_pkg::WORD_W-1:0] draws_due [$];

  // Output scrambling of one table word
  function automatic logic [mtrd_pkg::WORD_W-1:0] scramble(
    input logic [mtrd_pkg::WORD_W-1:0] w
  );
    logic [mtrd_pkg::WORD_W-1:0] t;
    t = w ^ {11'b0, w[31:11]};
    t = t ^ ({t[24:0], 7'b0} & mtrd_pkg::TEMPER_B);
    t = t ^ ({t[16:0], 15'b0} & mtrd_pkg::TEMPER_C);
    t = t ^ {18'b0, t[31:18]};
    return t;
  endfunction

  // Fill the table from the seed with the multiplicative recurrence
  function automatic void reseed_words();
    mt_words[0] = seed_reg;
    for (int i = 1; i < mtrd_pkg::STATE_WORDS; i++) begin
      mt_words[i] = mt_words[i-1] * mtrd_pkg::SEED_MULT;
    end
  endfunction

  // Regenerate all words in place
  function automatic void regenerate_words();
    int unsigned                 nxt;
    int unsigned                 far;
    logic [mtrd_pkg::WORD_W-1:0] mix;
    logic [mtrd_pkg::WORD_W-1:0] w;
    for (int unsigned k = 0; k < mtrd_pkg::STATE_WORDS; k++) begin
      nxt = (k + 1) % mtrd_pkg::STATE_WORDS;
      far = (k + mtrd_pkg::TWIST_OFFSET) % mtrd_pkg::STATE_WORDS;
      mix = {mt_words[k][31], mt_words[nxt][30:0]};
      w   = mt_words[far] ^ (mix >> 1);
      if (mix[0]) begin
        w = w ^ mtrd_pkg::MATRIX_WORD;
      end
      mt_words[k] = w;
    end
  endfunction

  // Advance the generator for one item and return its expected draw
  function automatic logic [mtrd_pkg::WORD_W-1:0] next_draw(
    input logic [mtrd_pkg::WORD_W-1:0] limit
  );
    logic [mtrd_pkg::WORD_W-1:0] y;
    if (limit == '0) begin
      return '0;
    end
    if (word_idx >= mtrd_pkg::STATE_WORDS) begin
      if (word_idx > mtrd_pkg::STATE_WORDS) begin
        reseed_words();
      end
      regenerate_words();
      word_idx = '0;
    end
    y = scramble(mt_words[word_idx]);
    word_idx = word_idx + 10'd1;
    return y % limit;
  endfunction

  // Track both channels and the seed port at each rising edge
  always @(posedge clk) begin
    logic [mtrd_pkg::WORD_W-1:0] want;
    if (rst) begin
      seed_reg = mtrd_pkg::SEED_RESET;
      word_idx = 10'(mtrd_pkg::STATE_WORDS + 1);
      draws_due.delete();
      fail_count = 0;
    end else begin
      // Check a returned item against the oldest expectation
      if (rsp_valid && !rsp_stall) begin
        if (draws_due.size() == 0) begin
          $error("value: no item expected, got %h", value);
          fail_count++;
        end else begin
          want = draws_due.pop_front();
          if (value !== want) begin
            $error("value: expected %h, got %h", want, value);
            fail_count++;
          end
        end
      end
      // Predict each accepted request
      if (req_valid && !req_stall) begin
        draws_due.push_back(next_draw(range_limit));
      end
      // A seed load marks the table for reseeding
      if (seed_valid && seed_ready) begin
        seed_reg = seed;
        word_idx = 10'(mtrd_pkg::STATE_WORDS + 1);
      end
    end
    outstanding = draws_due.size();
  end

endmodule

@@ dv/tb_mersenne_twister_ranged_draw_unit.sv @@
`timescale 1ns / 1ps

module tb_mersenne_twister_ranged_draw_unit;

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        req_valid   = 1'b0;
  logic                        req_stall;
  logic [mtrd_pkg::WORD_W-1:0] range_limit = '0;
  logic                        rsp_valid;
  logic                        rsp_stall   = 1'b0;
  logic [mtrd_pkg::WORD_W-1:0] value;
  logic                        seed_valid  = 1'b0;
  logic                        seed_ready;
  logic [mtrd_pkg::WORD_W-1:0] seed        = '0;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 10;
  int recv_stall_pct = 51;
  int draws_sent     = 0;
  int zero_draws     = 0;
  int seed_loads     = 0;

  // Limits at the edges of the field, sent under the reset seed
  logic [mtrd_pkg::WORD_W-1:0] probe_limits [14] = '{
    32'h0, 32'h1, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h2, 32'h3,
    32'h0, 32'hfffffffe, 32'd10, 32'h55555555, 32'haaaaaaaa, 32'h10000, 32'hffff
  };

  mersenne_twister_ranged_draw_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .range_limit (range_limit),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .value       (value),
    .seed_valid  (seed_valid),
    .seed_ready  (seed_ready),
    .seed        (seed)
  );

  mtrd_draw_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .range_limit (range_limit),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .value       (value),
    .seed_valid  (seed_valid),
    .seed_ready  (seed_ready),
    .seed        (seed),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    rsp_stall = (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Pick a limit: mostly full-width, with zeros, small values, powers of two, near max
  function automatic logic [mtrd_pkg::WORD_W-1:0] random_limit();
    case ($urandom_range(19))
      0:       return '0;
      1, 2:    return $urandom_range(16, 1);
      3:       return 32'h1 << $urandom_range(31);
      4:       return 32'hffffffff - $urandom_range(255);
      5:       return $urandom_range(1000, 1);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and hold it until accepted; valid stays high on return
  task automatic send_draw(input logic [mtrd_pkg::WORD_W-1:0] limit);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid   = 1'b0;
      range_limit = $urandom;
      @(negedge clk);
    end
    req_valid   = 1'b1;
    range_limit = limit;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    draws_sent++;
    if (limit == '0) begin
      zero_draws++;
    end
  endtask

  // Drop valid and hold off until every result is back and the block is quiet
  task automatic settle();
    req_valid = 1'b0;
    wait (outstanding == 0);
    repeat (50) @(negedge clk);
  endtask

  // Write the seed register while idle
  task automatic load_seed(input logic [mtrd_pkg::WORD_W-1:0] s);
    seed_valid = 1'b1;
    seed       = s;
    do @(posedge clk); while (!seed_ready);
    @(negedge clk);
    seed_valid = 1'b0;
    seed_loads++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Edge limits under the reset seed, a zero limit while reseed is pending
    foreach (probe_limits[i]) begin
      send_draw(probe_limits[i]);
    end
    settle();

    // Zero seed: every draw must come back as zero
    load_seed('0);
    send_draw(32'hffffffff);
    send_draw(32'h0);
    send_draw(32'd7);
    settle();

    // All-ones seed
    load_seed(32'hffffffff);
    send_draw(32'hffffffff);
    send_draw(32'h1);
    send_draw(32'h12345);
    settle();

    // One random seed for the rest, under three idling patterns
    load_seed($urandom);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 10; recv_stall_pct = 51; end
        1: begin send_idle_pct = 51; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (160) send_draw(random_limit());
      settle();
    end

    $display("Ran %0d draws (%0d with a zero limit) over %0d seed loads,",
             draws_sent, zero_draws, seed_loads);
    $display("with sender/receiver idling swapped and then removed.");
    if (fail_count == 0) begin
      $display("tb_mersenne_twister_ranged_draw_unit: done, clean");
    end else begin
      $display("tb_mersenne_twister_ranged_draw_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_mersenne_twister_ranged_draw_unit: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
sv/mtrd_pkg.sv
sv/mtrd_ram.sv
sv/mtrd_mod.sv
sv/mtrd_gen.sv
sv/mersenne_twister_ranged_draw_unit.sv
sv/mtrd_checker.sv
dv/mtrd_draw_checker.sv
dv/tb_mersenne_twister_ranged_draw_unit.sv
